@@ rtl/core/sli_pkg.sv @@
// Shared constants, codes and types for the sorted list insert block.
package sli_pkg;

    localparam int SLOTS   = 64;
    localparam int CELLS   = SLOTS - 1;
    localparam int STEP_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NEXT0   = 1 % CELLS;
    localparam int VALUE_W = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_ENTRY    = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic                       insert;
        logic                       rotate;
        logic signed [VALUE_W-1:0]  item;
    } cell_ctl_t;

endpackage

@@ rtl/core/sorted_list_insert.sv @@
// Top level: sorted value list as a chain of cells with insert and dump.
//
//  channel | direction | handshake           | words
//  in      | input     | in_valid/in_ready   | op, value
//  out     | output    | out_valid/out_ready | status, entry_value, last
//
// On an insert every cell compares against the new value at once, and the cells
// above the insertion point shift up by one.
// A dump rotates the ring of SLOTS-1 cells once around, one step a cycle, and
// entries leave cell 0; a stalled output holds the rotation if cell 0 is valid.
// An empty dump, an insert and an overflow each give a single word.
// Reset clears all cells to empty.
module sorted_list_insert (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic signed [sli_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [sli_pkg::VALUE_W-1:0] entry_value,
    output logic                               last
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    localparam logic [sli_pkg::STEP_W-1:0] STEP_LAST = sli_pkg::STEP_W'(sli_pkg::CELLS - 1);

    state_t                             state_reg;
    logic [sli_pkg::STEP_W-1:0]         step_reg;
    logic                               out_valid_reg;
    sli_pkg::status_t                   status_reg;
    logic signed [sli_pkg::VALUE_W-1:0] entry_value_reg;
    logic                               last_reg;

    logic signed [sli_pkg::VALUE_W-1:0] cell_value [sli_pkg::CELLS];
    logic                               cell_valid [sli_pkg::CELLS];
    logic                               cell_ins   [sli_pkg::CELLS];

    sli_pkg::cell_ctl_t ctl;
    logic               out_free;
    logic               in_fire;
    logic               full;
    logic               dump_last;
    logic               out_load;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign full      = cell_valid[sli_pkg::CELLS-1];
    assign dump_last = (step_reg == STEP_LAST) || !cell_valid[sli_pkg::NEXT0];

    assign ctl.insert = in_fire && (op == sli_pkg::OP_INSERT) && !full;
    assign ctl.rotate = (state_reg == S_DUMP) && (out_free || !cell_valid[0]);
    assign ctl.item   = value;

    assign out_load = (state_reg == S_IDLE)
                    ? (in_fire && ((op == sli_pkg::OP_INSERT) || !cell_valid[0]))
                    : (ctl.rotate && cell_valid[0]);

    for (genvar i = 0; i < sli_pkg::CELLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            sli_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_shift (1'b0),
                .prev_value ('0),
                .prev_valid (1'b0),
                .next_value (cell_value[(i + 1) % sli_pkg::CELLS]),
                .next_valid (cell_valid[(i + 1) % sli_pkg::CELLS]),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .ins_here   (cell_ins[i])
            );
        end
        else
        begin : g_rest
            sli_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_shift (cell_ins[i-1]),
                .prev_value (cell_value[i-1]),
                .prev_valid (cell_valid[i-1]),
                .next_value (cell_value[(i + 1) % sli_pkg::CELLS]),
                .next_valid (cell_valid[(i + 1) % sli_pkg::CELLS]),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .ins_here   (cell_ins[i])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= sli_pkg::ST_INSERTED;
            entry_value_reg <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (op == sli_pkg::OP_INSERT)
                        begin
                            status_reg      <= full ? sli_pkg::ST_OVERFLOW
                                                    : sli_pkg::ST_INSERTED;
                            entry_value_reg <= value;
                            last_reg        <= 1'b1;
                        end
                        else if (!cell_valid[0])
                        begin
                            status_reg      <= sli_pkg::ST_EMPTY;
                            entry_value_reg <= '0;
                            last_reg        <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_DUMP;
                            step_reg  <= '0;
                        end
                    end
                end
                S_DUMP:
                begin
                    if (ctl.rotate)
                    begin
                        if (cell_valid[0])
                        begin
                            status_reg      <= sli_pkg::ST_ENTRY;
                            entry_value_reg <= cell_value[0];
                            last_reg        <= dump_last;
                        end
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == STEP_LAST)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_value = entry_value_reg;
    assign last        = last_reg;

endmodule

@@ rtl/core/sli_cell.sv @@
// One storage cell of the sorted chain: shift-insert and ring rotation.
module sli_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sli_pkg::cell_ctl_t                 ctl,
    input  logic                               prev_shift,
    input  logic signed [sli_pkg::VALUE_W-1:0] prev_value,
    input  logic                               prev_valid,
    input  logic signed [sli_pkg::VALUE_W-1:0] next_value,
    input  logic                               next_valid,
    output logic signed [sli_pkg::VALUE_W-1:0] value,
    output logic                               valid,
    output logic                               ins_here
);

    logic signed [sli_pkg::VALUE_W-1:0] value_reg;
    logic signed [sli_pkg::VALUE_W-1:0] value_next;
    logic                               valid_reg;
    logic                               valid_next;

    assign ins_here = !valid_reg || (ctl.item < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.insert && ins_here)
        begin
            if (prev_shift)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = ctl.item;
                valid_next = 1'b1;
            end
        end
        else if (ctl.rotate)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

@@ rtl/core/sli_checker.sv @@
// Port-level checks for the sorted list insert block, bound to the top level.
module sli_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               op,
    input logic signed [sli_pkg::VALUE_W-1:0] value,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [1:0]                         status,
    input logic signed [sli_pkg::VALUE_W-1:0] entry_value,
    input logic                               last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(entry_value) && $stable(last))
        else $error("output word changed while stalled");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("input ready with no room at the output");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sli_pkg::ST_INSERTED || status == sli_pkg::ST_OVERFLOW
            || status == sli_pkg::ST_EMPTY) |-> last)
        else $error("single-word result without last");

    a_insert_echo: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == sli_pkg::OP_INSERT |=> out_valid && last
            && (status == sli_pkg::ST_INSERTED || status == sli_pkg::ST_OVERFLOW)
            && entry_value == $past(value))
        else $error("insert result missing or wrong");

endmodule

bind sorted_list_insert sli_checker u_sli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_value (entry_value),
    .last        (last)
);
